// File: src/esfl_pkg.sv
// shared types and constants of the slot free list
// request/response words, kind and status codes, controller states
// no dependencies
package esfl_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int CFG_W        = 10;
	localparam int SLOT_W       = 10;

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_INIT    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		status_t           status;
		logic [SLOT_W-1:0] high_water;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_FILL  = 4'b0100,
		S_CLEAR = 4'b1000
	} state_t;

endpackage

// File: src/esfl_mem.sv
// link and used-mark memories of the slot free list
// one shared read address, one shared write port, registered read data
// depends on nothing but its parameters
module esfl_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [AW-1:0] rd_link,
	output logic          rd_used,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] wr_link,
	input  logic          wr_used
);

	logic [AW-1:0] link_mem [DEPTH];
	logic          used_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_link;
			used_mem[wr_addr] <= wr_used;
		end
	end

	always_ff @(posedge clk) begin
		rd_link <= link_mem[rd_addr];
		rd_used <= used_mem[rd_addr];
	end

endmodule

// File: src/element_slot_free_list.sv
// allocate, release and unused kinds: accept captures the word and starts the memory read,
// then the execute state writes back and registers done; busy holds off a new word meanwhile
// initialize sweeps every slot, one memory entry a cycle, and registers done with the last write
// reset: arst_n clears control state, then a clearing pass over every entry zeroes the used
// marks while busy stays high; configuration writes are taken at any time
// results cannot be stalled: done is a single-cycle strobe with rsp beside it
module element_slot_free_list
	import esfl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int          IDX_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

	// control state
	state_t            state_q;
	logic [IDX_W-1:0]  sweep_q;     // slot index of the fill / clear sweep
	logic [IDX_W-1:0]  head_q;      // first free slot, 0 = empty list
	logic [IDX_W-1:0]  top_q;       // high-water index
	logic [CFG_W-1:0]  cfg_q;       // initial_in_use register
	logic              done_q;

	// captured request word for the execute cycle
	kind_t             kind_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [IDX_W-1:0]  fill_n_q;    // saturated used count of an initialize
	rsp_t              rsp_q;

	// memory interface
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  rd_link;
	logic              rd_used;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  wr_link;
	logic              wr_used;

	logic              accept;
	logic [IDX_W-1:0]  n_sat;
	logic [IDX_W-1:0]  slot_idx;
	logic              rel_ok;
	logic              sweep_end;

	// config port never stalls
	assign cfg_ready = 1'b1;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// initial_in_use saturates at the last slot
	assign n_sat = (32'(cfg_q) > 32'(CAPACITY - 1)) ? LAST : IDX_W'(cfg_q);

	// release target: nonzero, inside the memory and currently in use
	assign slot_idx = IDX_W'(slot_s1);
	assign rel_ok   = (slot_s1 != '0) && (32'(slot_s1) < 32'(CAPACITY)) && rd_used;

	assign sweep_end = (sweep_q == LAST);

	// release looks up the used mark of its slot, allocate the link of the head
	assign rd_addr = (req.kind == KIND_RELEASE) ? IDX_W'(req.slot) : head_q;

	// write-back: sweeps write every entry, execute writes the touched slot
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_link = '0;
		wr_used = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_FILL: begin
				wr_en = 1'b1;
				if (sweep_q != '0) begin
					if (sweep_q <= fill_n_q) begin
						wr_used = 1'b1;
					end else if (!sweep_end) begin
						// ascending chain, last free slot ends the list
						wr_link = sweep_q + IDX_W'(1);
					end
				end
			end
			S_EXEC: begin
				unique case (kind_s1)
					KIND_ALLOC: begin
						// popped slot: used, link cleared
						wr_en   = (head_q != '0);
						wr_addr = head_q;
						wr_used = 1'b1;
					end
					KIND_RELEASE: begin
						// pushed slot points at the old head
						wr_en   = rel_ok;
						wr_addr = slot_idx;
						wr_link = head_q;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	esfl_mem #(
		.DEPTH(CAPACITY),
		.AW   (IDX_W)
	) u_mem (
		.clk    (clk),
		.rd_addr(rd_addr),
		.rd_link(rd_link),
		.rd_used(rd_used),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_link(wr_link),
		.wr_used(wr_used)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// request capture, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= req.kind;
			slot_s1  <= req.slot;
			fill_n_q <= n_sat;
		end
	end

	// controller, list head and high-water index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sweep_q <= '0;
			head_q  <= '0;
			top_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_end) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						sweep_q <= '0;
						state_q <= (req.kind == KIND_INIT) ? S_FILL : S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					unique case (kind_s1)
						KIND_ALLOC: begin
							if (head_q != '0) begin
								head_q <= rd_link;
								if (head_q > top_q) begin
									top_q <= head_q;
								end
							end
						end
						KIND_RELEASE: begin
							if (rel_ok) begin
								head_q <= slot_idx;
								if (slot_idx == top_q) begin
									top_q <= top_q - IDX_W'(1);
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_FILL: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_end) begin
						sweep_q <= '0;
						// list empty when every slot starts in use
						head_q  <= (fill_n_q == LAST) ? '0 : fill_n_q + IDX_W'(1);
						top_q   <= fill_n_q;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response word, registered
	always_ff @(posedge clk) begin
		if (state_q == S_FILL && sweep_end) begin
			rsp_q.granted_slot <= '0;
			rsp_q.status       <= STATUS_OK;
			rsp_q.high_water   <= SLOT_W'(fill_n_q);
		end else if (state_q == S_EXEC) begin
			rsp_q.granted_slot <= '0;
			rsp_q.status       <= STATUS_OK;
			rsp_q.high_water   <= SLOT_W'(top_q);
			unique case (kind_s1)
				KIND_ALLOC: begin
					if (head_q == '0) begin
						rsp_q.status <= STATUS_EMPTY;
					end else begin
						rsp_q.granted_slot <= SLOT_W'(head_q);
						if (head_q > top_q) begin
							rsp_q.high_water <= SLOT_W'(head_q);
						end
					end
				end
				KIND_RELEASE: begin
					if (!rel_ok) begin
						rsp_q.status <= STATUS_INVALID;
					end else begin
						rsp_q.granted_slot <= slot_s1;
						if (slot_idx == top_q) begin
							rsp_q.high_water <= SLOT_W'(top_q - IDX_W'(1));
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: src/esfl_checker.sv
// port-level checks of the slot free list and the bind that attaches them
// depends on esfl_pkg and element_slot_free_list
module esfl_checker
	import esfl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// a result never appears right after an accepting edge
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(start && !busy))
		else $error("done one cycle after accept");

	// one word per strobe
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

	// an accepted word blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accept");

	// a failed request grants no slot
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != STATUS_OK) |-> (rsp.granted_slot == '0))
		else $error("slot granted on failure");

endmodule

bind element_slot_free_list esfl_checker u_esfl_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

// File: test/slot_list_checker.sv
// self-checking monitor for the slot free list: tracks the list state from the
// request and config words it sees and compares every response word
// depends on esfl_pkg
module slot_list_checker
	import esfl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  req_t             req,
	input  logic             done,
	input  rsp_t             rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [SLOT_W-1:0] link_mem [CAPACITY];
	bit                in_use   [CAPACITY];
	logic [SLOT_W-1:0] head;
	logic [SLOT_W-1:0] top;
	logic [CFG_W-1:0]  preset_count;
	rsp_t              owed_q [$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	// rebuild the chain: 1..n used, n+1..CAPACITY-1 free in ascending order
	function automatic void build_chain();
		int unsigned n;
		n = preset_count;
		if (n > CAPACITY - 1)
			n = CAPACITY - 1;
		link_mem[0] = '0;
		in_use[0]   = 0;
		for (int unsigned k = 1; k < CAPACITY; k++) begin
			in_use[k]   = (k <= n);
			link_mem[k] = (k <= n || k + 1 >= CAPACITY) ? '0 : SLOT_W'(k + 1);
		end
		head = (n + 1 < CAPACITY) ? SLOT_W'(n + 1) : '0;
		top  = SLOT_W'(n);
	endfunction

	function automatic rsp_t next_response(input req_t r);
		rsp_t              o;
		logic [SLOT_W-1:0] cur;
		o.granted_slot = '0;
		o.status       = STATUS_OK;
		case (r.kind)
			KIND_ALLOC: begin
				cur = head;
				if (cur == 0) begin
					o.status = STATUS_EMPTY;
				end else begin
					if (cur > top)
						top = cur;
					head          = link_mem[cur];
					link_mem[cur] = '0;
					in_use[cur]   = 1;
					o.granted_slot = cur;
				end
			end
			KIND_RELEASE: begin
				if (r.slot == 0 || int'(r.slot) >= CAPACITY || !in_use[r.slot]) begin
					o.status = STATUS_INVALID;
				end else begin
					in_use[r.slot]   = 0;
					link_mem[r.slot] = head;
					head             = r.slot;
					if (r.slot == top)
						top = top - 1'b1;
					o.granted_slot = r.slot;
				end
			end
			KIND_INIT: build_chain();
			default: ;
		endcase
		o.high_water = top;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int k = 0; k < CAPACITY; k++) begin
				link_mem[k] = '0;
				in_use[k]   = 0;
			end
			head         = '0;
			top          = '0;
			preset_count = '0;
			owed_q.delete();
		end else begin
			// the response of an older word is checked before a new word is taken
			if (done) begin
				if (owed_q.size() == 0) begin
					// a strobe with no word outstanding
					flag_mismatch("words outstanding at strobe", 0, 1);
				end else begin
					want = owed_q.pop_front();
					if (rsp.granted_slot !== want.granted_slot)
						flag_mismatch("granted_slot", rsp.granted_slot, want.granted_slot);
					if (rsp.status !== want.status)
						flag_mismatch("status", rsp.status, want.status);
					if (rsp.high_water !== want.high_water)
						flag_mismatch("high_water", rsp.high_water, want.high_water);
				end
			end
			if (start && !busy)
				owed_q.push_back(next_response(req));
			if (cfg_valid && cfg_ready)
				preset_count = cfg_data;
		end
		pending = owed_q.size();
	end

endmodule

// File: test/testbench.sv
// top of the slot free list bench: clock, reset, directed and random request
// words, config writes, progress watchdog and the final verdict
// depends on esfl_pkg, element_slot_free_list and slot_list_checker
module testbench
	import esfl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1300;
	localparam int QUIET_TAIL   = 1100;  // past this many random words, no gaps
	localparam int STALL_LIMIT  = 5000;  // well above a list build, which sweeps every slot

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             rsp;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	int               errors;
	int               pending;

	// kinds of the words in flight, so returned grants can feed the held pool
	logic [1:0]        inflight [$];
	// slots this side believes are in use, the source of well-formed frees
	logic [SLOT_W-1:0] held [$];
	logic [SLOT_W-1:0] last_freed;

	int sent_words, random_words, builds, grants, frees, refusals, rejects;
	int quiet_cycles;

	element_slot_free_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	slot_list_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bookkeeping at each rising edge: response words first, then new words
	always @(posedge clk) begin
		logic [1:0] k;
		if (done && inflight.size() != 0) begin
			k = inflight.pop_front();
			if (k == KIND_ALLOC && rsp.status == STATUS_OK) begin
				held.push_back(rsp.granted_slot);
				grants++;
			end else if (k == KIND_RELEASE && rsp.status == STATUS_OK) begin
				frees++;
			end
			if (rsp.status == STATUS_EMPTY)
				refusals++;
			if (rsp.status == STATUS_INVALID)
				rejects++;
		end
		if (start && !busy) begin
			inflight.push_back(req.kind);
			sent_words++;
		end

		// progress watchdog: any accepted word in either direction or config write resets it
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no progress for %0d cycles, %0d responses outstanding",
				STALL_LIMIT, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// present one request word at a falling edge and hold it until taken;
	// start stays high afterwards so a back-to-back word needs no extra edge
	task automatic send(input logic [1:0] k, input logic [SLOT_W-1:0] s, input int gap);
		req_t w;
		w.kind = kind_t'(k);
		w.slot = s;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// drop start and let every outstanding word come back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (inflight.size() != 0)
			@(negedge clk);
	endtask

	// only called with the block drained
	task automatic write_preset(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// new list build: the held pool restarts as slots 1..n
	task automatic rebuild(input logic [CFG_W-1:0] v);
		int n;
		drain();
		write_preset(v);
		n = (v > 1023) ? 1023 : v;
		held.delete();
		for (int k = 1; k <= n; k++)
			held.push_back(SLOT_W'(k));
		send(KIND_INIT, SLOT_W'($urandom), 0);
		builds++;
	endtask

	function automatic logic [CFG_W-1:0] pick_preset();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 2)
			return CFG_W'($urandom_range(1000, 1023));  // nearly full, runs dry fast
		if (r <= 4)
			return '0;
		if (r == 5)
			return $urandom_range(0, 1) ? CFG_W'(1022) : CFG_W'(1023);
		return CFG_W'($urandom_range(0, 1022));
	endfunction

	initial begin
		int               gap_pct, phase_len, gap, p, idx;
		logic [SLOT_W-1:0] s;

		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty list before any build, invalid frees, unused kind
		send(KIND_ALLOC, '0, 0);
		send(KIND_RELEASE, SLOT_W'(5), 0);
		send(KIND_RELEASE, '0, 0);
		send(2'd3, '1, 0);

		// full free list: pop order, high-water drop on freeing the top, double free
		drain();
		write_preset('0);
		send(KIND_INIT, '0, 0);
		send(KIND_ALLOC, '1, 0);
		send(KIND_ALLOC, '0, 0);
		send(KIND_ALLOC, '0, 0);
		send(KIND_RELEASE, SLOT_W'(3), 0);
		send(KIND_RELEASE, SLOT_W'(1), 0);
		send(KIND_RELEASE, SLOT_W'(1), 0);
		send(KIND_RELEASE, SLOT_W'(1023), 0);
		send(KIND_ALLOC, '0, 0);
		send(2'd3, SLOT_W'(682), 0);

		// oversized preset saturates: no free slot at all
		drain();
		write_preset('1);
		send(KIND_INIT, SLOT_W'(341), 0);
		send(KIND_ALLOC, '0, 0);
		send(KIND_RELEASE, SLOT_W'(1023), 0);
		send(KIND_ALLOC, '0, 0);
		send(KIND_RELEASE, SLOT_W'(1023), 0);

		// one free slot, the highest index
		drain();
		write_preset(CFG_W'(1022));
		send(KIND_INIT, '0, 0);
		send(KIND_ALLOC, '0, 0);
		send(KIND_ALLOC, '0, 0);
		send(KIND_RELEASE, SLOT_W'(512), 0);
		send(KIND_RELEASE, SLOT_W'(1022), 0);

		// random phases: each one a new build, then mostly well-formed grant/free
		// traffic drawn from the held pool, with some noise mixed in
		last_freed   = '0;
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			rebuild(pick_preset());
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 35;
			endcase
			phase_len = $urandom_range(40, 120);
			for (int i = 0; i < phase_len && random_words < RANDOM_WORDS; i++) begin
				gap = 0;
				if (random_words < QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
					gap = $urandom_range(1, 15);
				p = $urandom_range(0, 99);
				if (p < 80 && (p < 45 || held.size() == 0)) begin
					send(KIND_ALLOC, SLOT_W'($urandom), gap);
				end else if (p < 80) begin
					// free a held slot, often the highest one to move the high-water mark
					idx = $urandom_range(0, held.size() - 1);
					if ($urandom_range(0, 3) == 0)
						foreach (held[j])
							if (held[j] > held[idx])
								idx = j;
					s = held[idx];
					held.delete(idx);
					last_freed = s;
					send(KIND_RELEASE, s, gap);
				end else if (p < 88) begin
					send(KIND_RELEASE, SLOT_W'($urandom_range(0, 1023)), gap);
				end else if (p < 93) begin
					send(KIND_RELEASE, last_freed, gap);
				end else begin
					send(2'd3, SLOT_W'($urandom), gap);
				end
				random_words++;
			end
		end

		// wait out every response, then idle on for anything stray
		drain();
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);

		$display("%0d request words (%0d random) over %0d list builds", sent_words,
			random_words, builds);
		$display("%0d grants, %0d frees, %0d empty-list refusals, %0d rejected frees",
			grants, frees, refusals, rejects);
		if (errors == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
src/esfl_pkg.sv
src/esfl_mem.sv
src/element_slot_free_list.sv
src/esfl_checker.sv
test/slot_list_checker.sv
test/testbench.sv
